@@ design/odometry_pose_covariance_integrator_unit_macros.svh @@
// assertion macros used by the checker file
`ifndef ODOMETRY_POSE_COVARIANCE_INTEGRATOR_UNIT_MACROS_SVH
`define ODOMETRY_POSE_COVARIANCE_INTEGRATOR_UNIT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define OPCI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("opci assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define OPCI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("opci assertion failed");

`endif

@@ design/opci_pkg.sv @@
// types, constants and the operation sequence of the odometry integrator
`default_nettype none

package opci_pkg;

    localparam int      ANG_PI       = 25736;
    localparam int      ANG_TWO_PI   = 51472;
    localparam int      ANG_HALF_PI  = 12868;
    localparam int      CORDIC_STEPS = 16;
    localparam int      CORDIC_GAIN  = 652032874;
    localparam longint  DIAG_MAX     = 64'sd2147483647;
    localparam longint  OFF_MAX      = 64'sd2147483647;
    localparam longint  OFF_MIN      = -64'sd2147483648;
    localparam int      NUM_UOPS     = 51;
    localparam int      STEP_W       = $clog2(NUM_UOPS);
    localparam int      NOISE_RESET  = 655;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_heading;
        logic        [15:0] elapsed;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] factor_x;
        logic signed [31:0] factor_y;
        logic signed [15:0] factor_heading;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] pose_heading;
        logic        [30:0] cov_xx;
        logic signed [31:0] cov_xy;
        logic signed [31:0] cov_xh;
        logic        [30:0] cov_yy;
        logic signed [31:0] cov_yh;
        logic        [30:0] cov_hh;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] value;
    } t_cfg_wr;

    typedef enum logic [1:0] {
        REG_NOISE_X = 2'd0,
        REG_NOISE_Y = 2'd1,
        REG_NOISE_H = 2'd2
    } t_reg_idx;

    typedef enum logic [5:0] {
        SRC_VX, SRC_VY, SRC_VH, SRC_DT, SRC_DX, SRC_DY, SRC_DTH,
        SRC_S, SRC_C, SRC_GS, SRC_GC, SRC_A, SRC_B, SRC_A2, SRC_AB, SRC_BB,
        SRC_QX, SRC_QY, SRC_QH, SRC_QD, SRC_C2, SRC_S2, SRC_CS,
        SRC_NX, SRC_NY, SRC_NH, SRC_FANG, SRC_GANG,
        SRC_CXX, SRC_CXY, SRC_CXH, SRC_CYY, SRC_CYH, SRC_CHH, SRC_ONE
    } t_src;

    typedef enum logic [4:0] {
        DST_NONE, DST_DX, DST_DY, DST_DTH, DST_A, DST_B, DST_A2, DST_AB, DST_BB,
        DST_QX, DST_QY, DST_QH, DST_QD, DST_C2, DST_S2, DST_CS,
        DST_FPX, DST_FPY, DST_GPX, DST_GPY, DST_FANG, DST_GANG,
        DST_CXX, DST_CXY, DST_CXH, DST_CYY, DST_CYH, DST_CHH
    } t_dst;

    typedef enum logic [1:0] {
        ACC_ADD  = 2'b00,
        ACC_SUB  = 2'b01,
        ACC_ADD2 = 2'b10
    } t_mode;

    typedef enum logic [1:0] {
        WSH_0, WSH_12, WSH_15, WSH_16
    } t_wsh;

    typedef struct packed {
        t_src  src_a;
        t_src  src_b;
        logic  psh16;
        logic  first;
        t_mode mode;
        t_dst  dst;
        t_wsh  wsh;
    } t_uop;

    typedef struct packed {
        logic load;
        logic cord_start;
        logic mul_en;
        logic acc_en;
        logic publish;
        t_uop uop;
    } t_dp_cmd;

    typedef struct packed {
        logic cord_done;
    } t_dp_status;

    function automatic logic [16:0] atan_at(input logic [3:0] i);
        logic [16:0] v;
        case (i)
            4'd0:    v = 17'd51472;
            4'd1:    v = 17'd30386;
            4'd2:    v = 17'd16055;
            4'd3:    v = 17'd8150;
            4'd4:    v = 17'd4091;
            4'd5:    v = 17'd2047;
            4'd6:    v = 17'd1024;
            4'd7:    v = 17'd512;
            4'd8:    v = 17'd256;
            4'd9:    v = 17'd128;
            4'd10:   v = 17'd64;
            4'd11:   v = 17'd32;
            4'd12:   v = 17'd16;
            4'd13:   v = 17'd8;
            4'd14:   v = 17'd4;
            default: v = 17'd2;
        endcase
        return v;
    endfunction

    function automatic t_uop mk(input t_src a, input t_src b, input logic p,
                                input logic f, input t_mode m, input t_dst d,
                                input t_wsh w);
        t_uop u;
        u.src_a = a;
        u.src_b = b;
        u.psh16 = p;
        u.first = f;
        u.mode  = m;
        u.dst   = d;
        u.wsh   = w;
        return u;
    endfunction

    // one multiply-accumulate per entry, results written back on the last term
    function automatic t_uop uop_at(input logic [STEP_W-1:0] idx);
        t_uop u;
        case (idx)
            6'd0:    u = mk(SRC_VX,   SRC_DT,  1'b0, 1'b1, ACC_ADD,  DST_DX,   WSH_12);
            6'd1:    u = mk(SRC_VY,   SRC_DT,  1'b0, 1'b1, ACC_ADD,  DST_DY,   WSH_12);
            6'd2:    u = mk(SRC_VH,   SRC_DT,  1'b0, 1'b1, ACC_ADD,  DST_DTH,  WSH_15);
            6'd3:    u = mk(SRC_DX,   SRC_C,   1'b0, 1'b1, ACC_ADD,  DST_NONE, WSH_0);
            6'd4:    u = mk(SRC_DY,   SRC_S,   1'b0, 1'b0, ACC_SUB,  DST_FPX,  WSH_16);
            6'd5:    u = mk(SRC_DX,   SRC_S,   1'b0, 1'b1, ACC_ADD,  DST_NONE, WSH_0);
            6'd6:    u = mk(SRC_DY,   SRC_C,   1'b0, 1'b0, ACC_ADD,  DST_FPY,  WSH_16);
            6'd7:    u = mk(SRC_DX,   SRC_GC,  1'b0, 1'b1, ACC_ADD,  DST_NONE, WSH_0);
            6'd8:    u = mk(SRC_DY,   SRC_GS,  1'b0, 1'b0, ACC_SUB,  DST_GPX,  WSH_16);
            6'd9:    u = mk(SRC_DX,   SRC_GS,  1'b0, 1'b1, ACC_ADD,  DST_NONE, WSH_0);
            6'd10:   u = mk(SRC_DY,   SRC_GC,  1'b0, 1'b0, ACC_ADD,  DST_GPY,  WSH_16);
            6'd11:   u = mk(SRC_FANG, SRC_ONE, 1'b0, 1'b1, ACC_ADD,  DST_NONE, WSH_0);
            6'd12:   u = mk(SRC_DTH,  SRC_ONE, 1'b0, 1'b0, ACC_ADD,  DST_FANG, WSH_0);
            6'd13:   u = mk(SRC_GANG, SRC_ONE, 1'b0, 1'b1, ACC_ADD,  DST_NONE, WSH_0);
            6'd14:   u = mk(SRC_DTH,  SRC_ONE, 1'b0, 1'b0, ACC_ADD,  DST_GANG, WSH_0);
            6'd15:   u = mk(SRC_DX,   SRC_S,   1'b1, 1'b1, ACC_SUB,  DST_NONE, WSH_0);
            6'd16:   u = mk(SRC_DY,   SRC_C,   1'b1, 1'b0, ACC_SUB,  DST_A,    WSH_0);
            6'd17:   u = mk(SRC_DX,   SRC_C,   1'b1, 1'b1, ACC_ADD,  DST_NONE, WSH_0);
            6'd18:   u = mk(SRC_DY,   SRC_S,   1'b1, 1'b0, ACC_SUB,  DST_B,    WSH_0);
            6'd19:   u = mk(SRC_A,    SRC_A,   1'b1, 1'b1, ACC_ADD,  DST_A2,   WSH_0);
            6'd20:   u = mk(SRC_A,    SRC_B,   1'b1, 1'b1, ACC_ADD,  DST_AB,   WSH_0);
            6'd21:   u = mk(SRC_B,    SRC_B,   1'b1, 1'b1, ACC_ADD,  DST_BB,   WSH_0);
            6'd22:   u = mk(SRC_NX,   SRC_DT,  1'b0, 1'b1, ACC_ADD,  DST_QX,   WSH_16);
            6'd23:   u = mk(SRC_NY,   SRC_DT,  1'b0, 1'b1, ACC_ADD,  DST_QY,   WSH_16);
            6'd24:   u = mk(SRC_NH,   SRC_DT,  1'b0, 1'b1, ACC_ADD,  DST_QH,   WSH_16);
            6'd25:   u = mk(SRC_QX,   SRC_ONE, 1'b0, 1'b1, ACC_ADD,  DST_NONE, WSH_0);
            6'd26:   u = mk(SRC_QY,   SRC_ONE, 1'b0, 1'b0, ACC_SUB,  DST_QD,   WSH_0);
            6'd27:   u = mk(SRC_C,    SRC_C,   1'b1, 1'b1, ACC_ADD,  DST_C2,   WSH_0);
            6'd28:   u = mk(SRC_S,    SRC_S,   1'b1, 1'b1, ACC_ADD,  DST_S2,   WSH_0);
            6'd29:   u = mk(SRC_C,    SRC_S,   1'b1, 1'b1, ACC_ADD,  DST_CS,   WSH_0);
            6'd30:   u = mk(SRC_CXX,  SRC_ONE, 1'b0, 1'b1, ACC_ADD,  DST_NONE, WSH_0);
            6'd31:   u = mk(SRC_A,    SRC_CXH, 1'b1, 1'b0, ACC_ADD2, DST_NONE, WSH_0);
            6'd32:   u = mk(SRC_A2,   SRC_CHH, 1'b1, 1'b0, ACC_ADD,  DST_NONE, WSH_0);
            6'd33:   u = mk(SRC_C2,   SRC_QX,  1'b1, 1'b0, ACC_ADD,  DST_NONE, WSH_0);
            6'd34:   u = mk(SRC_S2,   SRC_QY,  1'b1, 1'b0, ACC_ADD,  DST_CXX,  WSH_0);
            6'd35:   u = mk(SRC_CXY,  SRC_ONE, 1'b0, 1'b1, ACC_ADD,  DST_NONE, WSH_0);
            6'd36:   u = mk(SRC_A,    SRC_CYH, 1'b1, 1'b0, ACC_ADD,  DST_NONE, WSH_0);
            6'd37:   u = mk(SRC_B,    SRC_CXH, 1'b1, 1'b0, ACC_ADD,  DST_NONE, WSH_0);
            6'd38:   u = mk(SRC_AB,   SRC_CHH, 1'b1, 1'b0, ACC_ADD,  DST_NONE, WSH_0);
            6'd39:   u = mk(SRC_CS,   SRC_QD,  1'b1, 1'b0, ACC_ADD,  DST_CXY,  WSH_0);
            6'd40:   u = mk(SRC_CYY,  SRC_ONE, 1'b0, 1'b1, ACC_ADD,  DST_NONE, WSH_0);
            6'd41:   u = mk(SRC_B,    SRC_CYH, 1'b1, 1'b0, ACC_ADD2, DST_NONE, WSH_0);
            6'd42:   u = mk(SRC_BB,   SRC_CHH, 1'b1, 1'b0, ACC_ADD,  DST_NONE, WSH_0);
            6'd43:   u = mk(SRC_S2,   SRC_QX,  1'b1, 1'b0, ACC_ADD,  DST_NONE, WSH_0);
            6'd44:   u = mk(SRC_C2,   SRC_QY,  1'b1, 1'b0, ACC_ADD,  DST_CYY,  WSH_0);
            6'd45:   u = mk(SRC_CXH,  SRC_ONE, 1'b0, 1'b1, ACC_ADD,  DST_NONE, WSH_0);
            6'd46:   u = mk(SRC_A,    SRC_CHH, 1'b1, 1'b0, ACC_ADD,  DST_CXH,  WSH_0);
            6'd47:   u = mk(SRC_CYH,  SRC_ONE, 1'b0, 1'b1, ACC_ADD,  DST_NONE, WSH_0);
            6'd48:   u = mk(SRC_B,    SRC_CHH, 1'b1, 1'b0, ACC_ADD,  DST_CYH,  WSH_0);
            6'd49:   u = mk(SRC_CHH,  SRC_ONE, 1'b0, 1'b1, ACC_ADD,  DST_NONE, WSH_0);
            6'd50:   u = mk(SRC_QH,   SRC_ONE, 1'b0, 1'b0, ACC_ADD,  DST_CHH,  WSH_0);
            default: u = mk(SRC_ONE,  SRC_ONE, 1'b0, 1'b1, ACC_ADD,  DST_NONE, WSH_0);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

@@ design/opci_if.sv @@
// handshake channels: input items, result items and register writes
`default_nettype none

interface opci_in_if import opci_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface opci_out_if import opci_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface opci_cfg_if import opci_pkg::*; ();
    logic    valid;
    logic    ready;
    t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/opci_cordic.sv @@
// iterative 16-step cordic giving sin and cos of a Q3.13 angle in Q.16
`default_nettype none

module opci_cordic import opci_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_angle,
    output logic                    o_done,
    output logic signed [17:0]      o_sin,
    output logic signed [17:0]      o_cos
);

    logic               r_busy;
    logic               r_done;
    logic [3:0]         r_iter;
    logic signed [32:0] r_x, r_y, n_x, n_y;
    logic signed [19:0] r_z, n_z;
    logic               r_neg;
    logic signed [15:0] w_ang;
    logic               w_neg;
    logic signed [32:0] w_xr, w_yr;

    // fold into [-half pi, half pi]; the result is negated when the angle was folded
    always_comb begin
        w_ang = i_angle;
        w_neg = 1'b0;
        if (i_angle > 16'(ANG_HALF_PI)) begin
            w_ang = i_angle - 16'(ANG_PI);
            w_neg = 1'b1;
        end else if (i_angle < -16'(ANG_HALF_PI)) begin
            w_ang = i_angle + 16'(ANG_PI);
            w_neg = 1'b1;
        end
    end

    always_comb begin
        if (r_z >= 0) begin
            n_x = r_x - (r_y >>> r_iter);
            n_y = r_y + (r_x >>> r_iter);
            n_z = r_z - $signed({3'd0, atan_at(r_iter)});
        end else begin
            n_x = r_x + (r_y >>> r_iter);
            n_y = r_y - (r_x >>> r_iter);
            n_z = r_z + $signed({3'd0, atan_at(r_iter)});
        end
        w_xr = (n_x + 33'sd8192) >>> 14;
        w_yr = (n_y + 33'sd8192) >>> 14;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 4'd1;
                if (r_iter == 4'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= 33'(CORDIC_GAIN);
            r_y   <= '0;
            r_z   <= 20'(w_ang) <<< 3;
            r_neg <= w_neg;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            if (r_iter == 4'(CORDIC_STEPS - 1)) begin
                o_cos <= r_neg ? -18'(w_xr) : 18'(w_xr);
                o_sin <= r_neg ? -18'(w_yr) : 18'(w_yr);
            end
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

@@ design/opci_datapath.sv @@
// pose and covariance state, shared multiplier, accumulator and write-back
`default_nettype none

module opci_datapath import opci_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_status      o_status,
    input  wire t_in_item   i_in_data,
    input  wire logic       i_cfg_valid,
    input  wire t_cfg_wr    i_cfg_data,
    output t_out_item       o_out_data
);

    logic signed [15:0] r_vx, r_vy, r_vh;
    logic        [15:0] r_dt;
    logic        [15:0] r_nx, r_ny, r_nh;
    logic signed [20:0] r_dx, r_dy;
    logic signed [17:0] r_dth;
    logic signed [21:0] r_a, r_b;
    logic signed [25:0] r_a2, r_ab, r_bb;
    logic signed [16:0] r_qx, r_qy, r_qh, r_qd;
    logic signed [17:0] r_c2, r_s2, r_cs;
    logic        [31:0] r_fpx, r_fpy, r_gpx, r_gpy;
    logic signed [15:0] r_fang, r_gang;
    logic signed [31:0] r_cxx, r_cxy, r_cxh, r_cyy, r_cyh, r_chh;
    logic signed [63:0] r_prod, r_acc, n_acc;
    t_out_item          r_out;

    logic signed [17:0] w_s, w_c, w_gs, w_gc;
    logic               w_done_f, w_done_g;
    logic signed [31:0] w_op_a, w_op_b;
    logic signed [63:0] w_prod, w_term, w_base, w_sh;
    logic signed [19:0] w_r0, w_r1;
    logic signed [15:0] w_wrap;
    logic signed [31:0] w_cld, w_clo;
    t_uop               w_u;

    opci_cordic u_cordic_f (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.cord_start),
        .i_angle (r_fang),
        .o_done  (w_done_f),
        .o_sin   (w_s),
        .o_cos   (w_c)
    );

    opci_cordic u_cordic_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.cord_start),
        .i_angle (r_gang),
        .o_done  (w_done_g),
        .o_sin   (w_gs),
        .o_cos   (w_gc)
    );

    assign o_status.cord_done = w_done_f & w_done_g;
    assign w_u = i_cmd.uop;

    function automatic logic signed [31:0] pick(input t_src sel);
        logic signed [31:0] v;
        case (sel)
            SRC_VX:   v = 32'(r_vx);
            SRC_VY:   v = 32'(r_vy);
            SRC_VH:   v = 32'(r_vh);
            SRC_DT:   v = $signed({16'd0, r_dt});
            SRC_DX:   v = 32'(r_dx);
            SRC_DY:   v = 32'(r_dy);
            SRC_DTH:  v = 32'(r_dth);
            SRC_S:    v = 32'(w_s);
            SRC_C:    v = 32'(w_c);
            SRC_GS:   v = 32'(w_gs);
            SRC_GC:   v = 32'(w_gc);
            SRC_A:    v = 32'(r_a);
            SRC_B:    v = 32'(r_b);
            SRC_A2:   v = 32'(r_a2);
            SRC_AB:   v = 32'(r_ab);
            SRC_BB:   v = 32'(r_bb);
            SRC_QX:   v = 32'(r_qx);
            SRC_QY:   v = 32'(r_qy);
            SRC_QH:   v = 32'(r_qh);
            SRC_QD:   v = 32'(r_qd);
            SRC_C2:   v = 32'(r_c2);
            SRC_S2:   v = 32'(r_s2);
            SRC_CS:   v = 32'(r_cs);
            SRC_NX:   v = $signed({16'd0, r_nx});
            SRC_NY:   v = $signed({16'd0, r_ny});
            SRC_NH:   v = $signed({16'd0, r_nh});
            SRC_FANG: v = 32'(r_fang);
            SRC_GANG: v = 32'(r_gang);
            SRC_CXX:  v = r_cxx;
            SRC_CXY:  v = r_cxy;
            SRC_CXH:  v = r_cxh;
            SRC_CYY:  v = r_cyy;
            SRC_CYH:  v = r_cyh;
            SRC_CHH:  v = r_chh;
            SRC_ONE:  v = 32'sd1;
            default:  v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        w_op_a = pick(w_u.src_a);
        w_op_b = pick(w_u.src_b);
        w_prod = w_op_a * w_op_b;
    end

    // accumulate one term, then shape the running sum for its destination
    always_comb begin
        w_term = w_u.psh16 ? (r_prod >>> 16) : r_prod;
        w_base = w_u.first ? 64'sd0 : r_acc;
        case (w_u.mode)
            ACC_ADD:  n_acc = w_base + w_term;
            ACC_SUB:  n_acc = w_base - w_term;
            ACC_ADD2: n_acc = w_base + (w_term <<< 1);
            default:  n_acc = w_base + w_term;
        endcase
        case (w_u.wsh)
            WSH_0:   w_sh = n_acc;
            WSH_12:  w_sh = n_acc >>> 12;
            WSH_15:  w_sh = n_acc >>> 15;
            WSH_16:  w_sh = n_acc >>> 16;
            default: w_sh = n_acc;
        endcase
        // heading wrap: sum lies within two turns of the range
        w_r0 = 20'(n_acc) + 20'(ANG_PI);
        w_r1 = w_r0;
        if (w_r0 < 0) begin
            w_r1 = w_r0 + 20'(ANG_TWO_PI);
            if (w_r1 < 0) begin
                w_r1 = w_r1 + 20'(ANG_TWO_PI);
            end
        end else if (w_r0 >= 20'(ANG_TWO_PI)) begin
            w_r1 = w_r0 - 20'(ANG_TWO_PI);
            if (w_r1 >= 20'(ANG_TWO_PI)) begin
                w_r1 = w_r1 - 20'(ANG_TWO_PI);
            end
        end
        w_wrap = 16'(w_r1 - 20'(ANG_PI));
        if (n_acc < 0) begin
            w_cld = '0;
        end else if (n_acc > DIAG_MAX) begin
            w_cld = 32'(DIAG_MAX);
        end else begin
            w_cld = 32'(n_acc);
        end
        if (n_acc > OFF_MAX) begin
            w_clo = 32'(OFF_MAX);
        end else if (n_acc < OFF_MIN) begin
            w_clo = 32'(OFF_MIN);
        end else begin
            w_clo = 32'(n_acc);
        end
    end

    // block state, set by reset: noise levels to their reset value, the rest cleared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx   <= 16'(NOISE_RESET);
            r_ny   <= 16'(NOISE_RESET);
            r_nh   <= 16'(NOISE_RESET);
            r_fpx  <= '0;
            r_fpy  <= '0;
            r_gpx  <= '0;
            r_gpy  <= '0;
            r_fang <= '0;
            r_gang <= '0;
            r_cxx  <= '0;
            r_cxy  <= '0;
            r_cxh  <= '0;
            r_cyy  <= '0;
            r_cyh  <= '0;
            r_chh  <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_data.index)
                    REG_NOISE_X: r_nx <= i_cfg_data.value;
                    REG_NOISE_Y: r_ny <= i_cfg_data.value;
                    REG_NOISE_H: r_nh <= i_cfg_data.value;
                    default: ;
                endcase
            end
            if (i_cmd.acc_en) begin
                case (w_u.dst)
                    DST_FPX:  r_fpx  <= r_fpx + w_sh[31:0];
                    DST_FPY:  r_fpy  <= r_fpy + w_sh[31:0];
                    DST_GPX:  r_gpx  <= r_gpx + w_sh[31:0];
                    DST_GPY:  r_gpy  <= r_gpy + w_sh[31:0];
                    DST_FANG: r_fang <= w_wrap;
                    DST_GANG: r_gang <= w_wrap;
                    DST_CXX:  r_cxx  <= w_cld;
                    DST_CYY:  r_cyy  <= w_cld;
                    DST_CHH:  r_chh  <= w_cld;
                    DST_CXY:  r_cxy  <= w_clo;
                    DST_CXH:  r_cxh  <= w_clo;
                    DST_CYH:  r_cyh  <= w_clo;
                    default: ;
                endcase
            end
        end
    end

    // per-item scratch values and the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vx <= i_in_data.vel_x;
            r_vy <= i_in_data.vel_y;
            r_vh <= i_in_data.vel_heading;
            r_dt <= i_in_data.elapsed;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.acc_en) begin
            r_acc <= n_acc;
            case (w_u.dst)
                DST_DX:  r_dx  <= w_sh[20:0];
                DST_DY:  r_dy  <= w_sh[20:0];
                DST_DTH: r_dth <= w_sh[17:0];
                DST_A:   r_a   <= w_sh[21:0];
                DST_B:   r_b   <= w_sh[21:0];
                DST_A2:  r_a2  <= w_sh[25:0];
                DST_AB:  r_ab  <= w_sh[25:0];
                DST_BB:  r_bb  <= w_sh[25:0];
                DST_QX:  r_qx  <= w_sh[16:0];
                DST_QY:  r_qy  <= w_sh[16:0];
                DST_QH:  r_qh  <= w_sh[16:0];
                DST_QD:  r_qd  <= w_sh[16:0];
                DST_C2:  r_c2  <= w_sh[17:0];
                DST_S2:  r_s2  <= w_sh[17:0];
                DST_CS:  r_cs  <= w_sh[17:0];
                default: ;
            endcase
        end
        if (i_cmd.publish) begin
            r_out.factor_x       <= r_fpx;
            r_out.factor_y       <= r_fpy;
            r_out.factor_heading <= r_fang;
            r_out.pose_x         <= r_gpx;
            r_out.pose_y         <= r_gpy;
            r_out.pose_heading   <= r_gang;
            r_out.cov_xx         <= r_cxx[30:0];
            r_out.cov_xy         <= r_cxy;
            r_out.cov_xh         <= r_cxh;
            r_out.cov_yy         <= r_cyy[30:0];
            r_out.cov_yh         <= r_cyh;
            r_out.cov_hh         <= r_chh[30:0];
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

@@ design/opci_ctrl.sv @@
// controller: sequences cordic, multiply-accumulate steps and result hand-off
`default_nettype none

module opci_ctrl import opci_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    input  wire t_dp_status  i_status,
    output t_dp_cmd          o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CORD = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_ACC  = 5'b01000,
        ST_PUSH = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    always_comb begin
        n_state          = r_state;
        n_step           = r_step;
        o_cmd            = '0;
        o_cmd.uop        = uop_at(r_step);
        o_in_ready       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.cord_start = 1'b1;
                    n_state          = ST_CORD;
                end
            end
            ST_CORD: begin
                n_step = '0;
                if (i_status.cord_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_step       = r_step + 1'b1;
                n_state      = (r_step == STEP_W'(NUM_UOPS - 1)) ? ST_PUSH : ST_MUL;
            end
            ST_PUSH: begin
                // wait until the output register is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ design/odometry_pose_covariance_integrator_unit.sv @@
// top level of the odometry pose and covariance integrator
// Each accepted tick (body velocities and elapsed time) updates the factor pose,
// the global pose and the 3x3 factor covariance, and produces one result
// carrying the updated values. A tick is worked in order: the accept, the
// cordic (16 iterations and the done flag; two units, factor and global heading,
// running side by side), 51 multiply-accumulate operations, each a multiply
// state and an accumulate state, through the single shared 32x32 multiplier,
// and the load of the output register, which waits while an untaken result
// still holds it. The input is ready again right after that; a finished
// result waits in the output register while the next tick is taken. Register
// writes are accepted in every cycle and take effect at once.
`default_nettype none

module odometry_pose_covariance_integrator_unit import opci_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    opci_in_if.sink    i_in,
    opci_out_if.source o_out,
    opci_cfg_if.sink   i_cfg
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign i_cfg.ready = 1'b1;

    opci_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    opci_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in.data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_out_data  (o_out.data)
    );

endmodule

`default_nettype wire

@@ design/opci_checker.sv @@
// port-level checks of the integrator, bound to the top level
`default_nettype none
`include "odometry_pose_covariance_integrator_unit_macros.svh"

module opci_checker import opci_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      i_in_ready,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item i_out_data
);

    `OPCI_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `OPCI_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_data))
    // a transfer on the input starts the work, so the input closes at once
    `OPCI_ASSERT_NEXT(a_busy_after_take, i_in_valid && i_in_ready, !i_in_ready)
    `OPCI_ASSERT_IMPL(a_heading_range, i_out_valid, (i_out_data.pose_heading >= -16'sd25736) && (i_out_data.pose_heading <= 16'sd25735) && (i_out_data.factor_heading >= -16'sd25736) && (i_out_data.factor_heading <= 16'sd25735))

endmodule

bind odometry_pose_covariance_integrator_unit opci_checker u_opci_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire
